@@ design/aarm_pkg.sv @@
// aarm_pkg: shared types, constants and per-cell datapath functions for the
// axis-angle rotation matrix pipeline.
// No dependencies; used by aarm_cell, aarm_skid and the top level.
package aarm_pkg;

    localparam int QB        = 30;
    localparam int MAX_OUT_W = 26;
    localparam int N_COEF    = 9;

    // one turn / (2*pi) in Q32, and pi/2 in Q30
    localparam logic [29:0] INV_TWO_PI = 30'd683565276;
    localparam logic [30:0] HALF_PI    = 31'd1686629713;
    localparam logic [30:0] Q_ONE      = 31'h4000_0000;

    typedef enum logic [4:0] {
        OP_ABS,
        OP_NORM,
        OP_SQUARE,
        OP_SUM,
        OP_SQRT,
        OP_DIV_INIT,
        OP_DIV,
        OP_TMUL,
        OP_QEST,
        OP_TFIX,
        OP_SIN_OUT,
        OP_SIGN,
        OP_PAIR,
        OP_MOMC,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } quad_t;

    // everything an item carries down the chain
    typedef struct packed {
        logic [2:0][31:0] ax;
        logic [31:0]      ang;
        logic             zero;
        logic [2:0]       neg;
        logic [31:0]      mx;
        logic [2:0][31:0] mag;
        logic [2:0][59:0] sq;
        logic [61:0]      sqn;
        logic [63:0]      root;
        logic [2:0][31:0] drem;
        logic [2:0][30:0] quo;
        logic [61:0]      aprod;
        quad_t            quad;
        logic [1:0][30:0] arg;
        logic [1:0][30:0] x;
        logic [1:0][31:0] x2;
        logic [1:0][30:0] t;
        logic [1:0][31:0] v;
        logic [1:0][31:0] q0;
        logic [1:0][30:0] s;
        logic [31:0]      sn;
        logic [31:0]      cs;
        logic [32:0]      omc;
        logic [2:0][31:0] u;
        logic [5:0][31:0] pr;
        logic [2:0][31:0] us;
        logic [5:0][32:0] mo;
        logic [N_COEF-1:0][MAX_OUT_W-1:0] m;
    } item_t;

    typedef struct packed {
        logic                             zero;
        logic [N_COEF-1:0][MAX_OUT_W-1:0] m;
    } res_t;

    // taylor divisors of the sine polynomial
    function automatic logic [6:0] sin_div(input int k);
        logic [6:0] r;
        case (k)
            0:       r = 7'd110;
            1:       r = 7'd72;
            2:       r = 7'd42;
            3:       r = 7'd20;
            default: r = 7'd6;
        endcase
        return r;
    endfunction

    // floor(2^36 / divisor)
    function automatic logic [33:0] sin_recip(input int k);
        logic [33:0] r;
        case (k)
            0:       r = 34'd624722515;
            1:       r = 34'd954437176;
            2:       r = 34'd1636178017;
            3:       r = 34'd3435973836;
            default: r = 34'd11453246122;
        endcase
        return r;
    endfunction

    // q30 product, rounded half up
    function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        logic signed [65:0] r;
        p = a * b;
        r = (p + 66'sd536870912) >>> QB;
        return r[32:0];
    endfunction

    function automatic logic [MAX_OUT_W-1:0] round_sat(input logic signed [33:0] sum,
                                                       input int frac);
        logic signed [33:0] rnd;
        logic signed [33:0] lim;
        rnd = (sum + (34'sd1 <<< (QB - frac - 1))) >>> (QB - frac);
        lim = 34'sd1 <<< frac;
        if (rnd > lim)
        begin
            rnd = lim;
        end
        if (rnd < -lim)
        begin
            rnd = -lim;
        end
        return rnd[MAX_OUT_W-1:0];
    endfunction

    function automatic item_t cell_op(input op_t op, input int arg, input int frac,
                                      input item_t d);
        item_t              o;
        int                 i;
        int                 msb;
        logic signed [61:0] aprod_s;
        logic [31:0]        phase;
        logic [61:0]        p62;
        logic [62:0]        p63;
        logic [65:0]        p66;
        logic [38:0]        p39;
        logic [63:0]        bitv;
        logic [63:0]        trial;
        logic [32:0]        dtrial;
        logic [31:0]        rem;
        logic [31:0]        qv;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic signed [31:0] sn_v;
        logic signed [31:0] cs_v;
        logic signed [33:0] sum;
        logic [31:0]        uq;
        o   = d;
        msb = 0;
        case (op)
            OP_ABS:
            begin
                o.mx = '0;
                for (i = 0; i < 3; i++)
                begin
                    o.neg[i] = d.ax[i][31];
                    o.mag[i] = d.ax[i][31] ? 32'(-d.ax[i]) : d.ax[i];
                    if (o.mag[i] > o.mx)
                    begin
                        o.mx = o.mag[i];
                    end
                end
                o.zero  = (o.mx == '0);
                aprod_s = $signed(d.ang) * $signed({1'b0, INV_TWO_PI});
                o.aprod = aprod_s;
            end
            OP_NORM:
            begin
                // bring the largest magnitude into [2^29, 2^30)
                for (i = 0; i < 32; i++)
                begin
                    if (d.mx[i])
                    begin
                        msb = i;
                    end
                end
                for (i = 0; i < 3; i++)
                begin
                    if (msb > 29)
                    begin
                        o.mag[i] = d.mag[i] >> (msb - 29);
                    end
                    else
                    begin
                        o.mag[i] = d.mag[i] << (29 - msb);
                    end
                end
                phase    = 32'(d.aprod >> frac);
                o.quad   = quad_t'(phase[31:30]);
                o.arg[0] = {1'b0, phase[29:0]};
                o.arg[1] = Q_ONE - {1'b0, phase[29:0]};
            end
            OP_SQUARE:
            begin
                for (i = 0; i < 3; i++)
                begin
                    o.sq[i] = d.mag[i][29:0] * d.mag[i][29:0];
                end
                for (i = 0; i < 2; i++)
                begin
                    p62     = d.arg[i] * HALF_PI;
                    o.x[i]  = p62[60:30];
                end
            end
            OP_SUM:
            begin
                o.sqn  = {2'b0, d.sq[0]} + {2'b0, d.sq[1]} + {2'b0, d.sq[2]};
                o.root = '0;
                for (i = 0; i < 2; i++)
                begin
                    p62     = d.x[i] * d.x[i];
                    o.x2[i] = p62[61:30];
                    o.t[i]  = Q_ONE;
                end
            end
            OP_SQRT:
            begin
                bitv  = 64'd1 << arg;
                trial = d.root + bitv;
                if ({2'b0, d.sqn} >= trial)
                begin
                    o.sqn  = 62'({2'b0, d.sqn} - trial);
                    o.root = (d.root >> 1) + bitv;
                end
                else
                begin
                    o.root = d.root >> 1;
                end
            end
            OP_DIV_INIT:
            begin
                for (i = 0; i < 3; i++)
                begin
                    o.drem[i] = {1'b0, d.mag[i][31:1]};
                end
                o.quo = '0;
            end
            OP_DIV:
            begin
                for (i = 0; i < 3; i++)
                begin
                    // dividend is mag * 2^30, so only its bit 30 can be set here
                    dtrial = {d.drem[i], (arg == 30) ? d.mag[i][0] : 1'b0};
                    if (dtrial >= {1'b0, d.root[31:0]})
                    begin
                        o.drem[i]     = 32'(dtrial - {1'b0, d.root[31:0]});
                        o.quo[i][arg] = 1'b1;
                    end
                    else
                    begin
                        o.drem[i] = dtrial[31:0];
                    end
                end
            end
            OP_TMUL:
            begin
                for (i = 0; i < 2; i++)
                begin
                    p63    = d.x2[i] * d.t[i];
                    o.v[i] = p63[61:30];
                end
            end
            OP_QEST:
            begin
                // reciprocal estimate, low by at most one
                for (i = 0; i < 2; i++)
                begin
                    p66     = d.v[i] * sin_recip(arg);
                    o.q0[i] = {2'b0, p66[65:36]};
                end
            end
            OP_TFIX:
            begin
                for (i = 0; i < 2; i++)
                begin
                    p39    = d.q0[i] * sin_div(arg);
                    rem    = d.v[i] - p39[31:0];
                    qv     = d.q0[i] + ((rem >= {25'd0, sin_div(arg)}) ? 32'd1 : 32'd0);
                    o.t[i] = Q_ONE - qv[30:0];
                end
            end
            OP_SIN_OUT:
            begin
                for (i = 0; i < 2; i++)
                begin
                    p62    = d.x[i] * d.t[i];
                    o.s[i] = p62[60:30];
                end
            end
            OP_SIGN:
            begin
                sa = $signed({1'b0, d.s[0]});
                sb = $signed({1'b0, d.s[1]});
                case (d.quad)
                    QUAD_I:
                    begin
                        sn_v = sa;
                        cs_v = sb;
                    end
                    QUAD_II:
                    begin
                        sn_v = sb;
                        cs_v = -sa;
                    end
                    QUAD_III:
                    begin
                        sn_v = -sa;
                        cs_v = -sb;
                    end
                    default:
                    begin
                        sn_v = -sb;
                        cs_v = sa;
                    end
                endcase
                o.sn  = sn_v;
                o.cs  = cs_v;
                o.omc = $signed(33'sd1073741824) - $signed({cs_v[31], cs_v});
                for (i = 0; i < 3; i++)
                begin
                    uq       = {1'b0, d.quo[i]};
                    o.u[i]   = d.neg[i] ? 32'(-uq) : uq;
                end
            end
            OP_PAIR:
            begin
                o.pr[0] = 32'(mulq({d.u[0][31], d.u[0]}, {d.u[0][31], d.u[0]}));
                o.pr[1] = 32'(mulq({d.u[1][31], d.u[1]}, {d.u[1][31], d.u[1]}));
                o.pr[2] = 32'(mulq({d.u[2][31], d.u[2]}, {d.u[2][31], d.u[2]}));
                o.pr[3] = 32'(mulq({d.u[0][31], d.u[0]}, {d.u[1][31], d.u[1]}));
                o.pr[4] = 32'(mulq({d.u[1][31], d.u[1]}, {d.u[2][31], d.u[2]}));
                o.pr[5] = 32'(mulq({d.u[2][31], d.u[2]}, {d.u[0][31], d.u[0]}));
                for (i = 0; i < 3; i++)
                begin
                    o.us[i] = 32'(mulq({d.u[i][31], d.u[i]}, {d.sn[31], d.sn}));
                end
            end
            OP_MOMC:
            begin
                for (i = 0; i < 6; i++)
                begin
                    o.mo[i] = mulq(d.omc, {d.pr[i][31], d.pr[i]});
                end
            end
            OP_OUT:
            begin
                sum = $signed(d.mo[0]) + $signed(d.cs);
                o.m[0] = round_sat(sum, frac);
                sum = $signed(d.mo[3]) - $signed(d.us[2]);
                o.m[1] = round_sat(sum, frac);
                sum = $signed(d.mo[5]) + $signed(d.us[1]);
                o.m[2] = round_sat(sum, frac);
                sum = $signed(d.mo[3]) + $signed(d.us[2]);
                o.m[3] = round_sat(sum, frac);
                sum = $signed(d.mo[1]) + $signed(d.cs);
                o.m[4] = round_sat(sum, frac);
                sum = $signed(d.mo[4]) - $signed(d.us[0]);
                o.m[5] = round_sat(sum, frac);
                sum = $signed(d.mo[5]) - $signed(d.us[1]);
                o.m[6] = round_sat(sum, frac);
                sum = $signed(d.mo[4]) + $signed(d.us[0]);
                o.m[7] = round_sat(sum, frac);
                sum = $signed(d.mo[2]) + $signed(d.cs);
                o.m[8] = round_sat(sum, frac);
                if (d.zero)
                begin
                    // zero-length axis: identity
                    for (i = 0; i < N_COEF; i++)
                    begin
                        o.m[i] = (i == 0 || i == 4 || i == 8) ?
                                 MAX_OUT_W'(34'sd1 <<< frac) : '0;
                    end
                end
            end
            default:
            begin
                o = d;
            end
        endcase
        return o;
    endfunction

endpackage

@@ design/aarm_cell.sv @@
// aarm_cell: one stage of the rotation-matrix chain; applies one datapath
// step to the item and hands it on. Depends on aarm_pkg.
module aarm_cell #(
    parameter aarm_pkg::op_t OP   = aarm_pkg::OP_ABS,
    parameter int            ARG  = 0,
    parameter int            FRAC = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  aarm_pkg::item_t in_item,
    output logic            out_valid,
    output aarm_pkg::item_t out_item
);

    logic            valid_reg;
    aarm_pkg::item_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= aarm_pkg::cell_op(OP, ARG, FRAC, in_item);
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ design/aarm_skid.sv @@
// aarm_skid: two-entry output buffer that lets the chain keep moving while
// one result waits. Depends on aarm_pkg.
module aarm_skid (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  aarm_pkg::res_t push_data,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output aarm_pkg::res_t out_data
);

    logic           out_valid_reg;
    logic           spare_valid_reg;
    aarm_pkg::res_t out_data_reg;
    aarm_pkg::res_t spare_data_reg;
    logic           pop;
    logic           push_ok;

    assign room    = !spare_valid_reg;
    assign pop     = out_valid_reg && out_ready;
    assign push_ok = push && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= push_ok;
        end
        else if (pop)
        begin
            if (spare_valid_reg)
            begin
                spare_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push_ok;
            end
        end
        else if (push_ok)
        begin
            spare_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_data_reg <= spare_valid_reg ? spare_data_reg : push_data;
        end
        if (out_valid_reg && !pop && push_ok)
        begin
            spare_data_reg <= push_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ design/axis_angle_rotation_matrix.sv @@
// axis_angle_rotation_matrix: axis-angle to 3x3 rotation matrix, built as a
// chain of aarm_cell stages feeding an aarm_skid output buffer. Uses aarm_pkg.
//
//   port group  dir  tdata (low bit up)                      tuser
//   s_axis      in   axis_x, axis_y, axis_z, angle (32 each)  -
//   m_axis      out  m00..m22 (FRAC_BITS+2 each), zero pad    zero_axis
//
// one request per cycle while the chain is not stopped; latency is set by
// the 32 square-root cells and 31 quotient cells, and by the output buffer
// the whole chain advances together and stops only while the two-entry output
// buffer is full; one finished result may wait without blocking input
// reset clears every valid bit; data registers are not reset
module axis_angle_rotation_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // axis_x [31:0], axis_y [63:32], axis_z [95:64], angle [127:96]
    input  logic [127:0]                              s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (FRAC_BITS+2 each), zero pad
    output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0]      m_axis_tdata,
    // zero_axis
    output logic                                      m_axis_tuser
);

    localparam int OUT_W    = FRAC_BITS + 2;
    localparam int N_SQRT   = 32;
    localparam int N_DIV    = 31;
    localparam int N_TAYLOR = 5;
    localparam int S_SQRT   = 4;
    localparam int S_DINIT  = S_SQRT + N_SQRT;
    localparam int S_DIV    = S_DINIT + 1;
    localparam int S_SIN    = S_DIV + N_DIV;
    localparam int S_TAIL   = S_SIN + 3 * N_TAYLOR;
    localparam int N_CELL   = S_TAIL + 5;

    logic                  en;
    logic [N_CELL:0]       vld;
    aarm_pkg::item_t       itm [N_CELL+1];
    aarm_pkg::res_t        res_in;
    aarm_pkg::res_t        res_out;

    always_comb
    begin
        itm[0]       = '0;
        itm[0].ax[0] = s_axis_tdata[31:0];
        itm[0].ax[1] = s_axis_tdata[63:32];
        itm[0].ax[2] = s_axis_tdata[95:64];
        itm[0].ang   = s_axis_tdata[127:96];
    end

    assign vld[0]        = s_axis_tvalid;
    assign s_axis_tready = en;

    aarm_cell #(.OP(aarm_pkg::OP_ABS), .ARG(0), .FRAC(FRAC_BITS)) u_abs (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(vld[0]), .in_item(itm[0]), .out_valid(vld[1]), .out_item(itm[1])
    );
    aarm_cell #(.OP(aarm_pkg::OP_NORM), .ARG(0), .FRAC(FRAC_BITS)) u_norm (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(vld[1]), .in_item(itm[1]), .out_valid(vld[2]), .out_item(itm[2])
    );
    aarm_cell #(.OP(aarm_pkg::OP_SQUARE), .ARG(0), .FRAC(FRAC_BITS)) u_square (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(vld[2]), .in_item(itm[2]), .out_valid(vld[3]), .out_item(itm[3])
    );
    aarm_cell #(.OP(aarm_pkg::OP_SUM), .ARG(0), .FRAC(FRAC_BITS)) u_sum (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(vld[3]), .in_item(itm[3]), .out_valid(vld[4]), .out_item(itm[4])
    );

    // one root bit per cell, from 2^62 down
    for (genvar k = 0; k < N_SQRT; k++)
    begin : g_sqrt
        aarm_cell #(.OP(aarm_pkg::OP_SQRT), .ARG(62 - 2 * k), .FRAC(FRAC_BITS)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(vld[S_SQRT+k]), .in_item(itm[S_SQRT+k]),
            .out_valid(vld[S_SQRT+k+1]), .out_item(itm[S_SQRT+k+1])
        );
    end

    aarm_cell #(.OP(aarm_pkg::OP_DIV_INIT), .ARG(0), .FRAC(FRAC_BITS)) u_dinit (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(vld[S_DINIT]), .in_item(itm[S_DINIT]),
        .out_valid(vld[S_DIV]), .out_item(itm[S_DIV])
    );

    // one quotient bit per cell for all three components
    for (genvar k = 0; k < N_DIV; k++)
    begin : g_div
        aarm_cell #(.OP(aarm_pkg::OP_DIV), .ARG(N_DIV - 1 - k), .FRAC(FRAC_BITS)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(vld[S_DIV+k]), .in_item(itm[S_DIV+k]),
            .out_valid(vld[S_DIV+k+1]), .out_item(itm[S_DIV+k+1])
        );
    end

    // each taylor term: multiply, reciprocal estimate, correct
    for (genvar k = 0; k < N_TAYLOR; k++)
    begin : g_taylor
        aarm_cell #(.OP(aarm_pkg::OP_TMUL), .ARG(k), .FRAC(FRAC_BITS)) u_tmul (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(vld[S_SIN+3*k]), .in_item(itm[S_SIN+3*k]),
            .out_valid(vld[S_SIN+3*k+1]), .out_item(itm[S_SIN+3*k+1])
        );
        aarm_cell #(.OP(aarm_pkg::OP_QEST), .ARG(k), .FRAC(FRAC_BITS)) u_qest (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(vld[S_SIN+3*k+1]), .in_item(itm[S_SIN+3*k+1]),
            .out_valid(vld[S_SIN+3*k+2]), .out_item(itm[S_SIN+3*k+2])
        );
        aarm_cell #(.OP(aarm_pkg::OP_TFIX), .ARG(k), .FRAC(FRAC_BITS)) u_tfix (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(vld[S_SIN+3*k+2]), .in_item(itm[S_SIN+3*k+2]),
            .out_valid(vld[S_SIN+3*k+3]), .out_item(itm[S_SIN+3*k+3])
        );
    end

    aarm_cell #(.OP(aarm_pkg::OP_SIN_OUT), .ARG(0), .FRAC(FRAC_BITS)) u_sin_out (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(vld[S_TAIL]), .in_item(itm[S_TAIL]),
        .out_valid(vld[S_TAIL+1]), .out_item(itm[S_TAIL+1])
    );
    aarm_cell #(.OP(aarm_pkg::OP_SIGN), .ARG(0), .FRAC(FRAC_BITS)) u_sign (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(vld[S_TAIL+1]), .in_item(itm[S_TAIL+1]),
        .out_valid(vld[S_TAIL+2]), .out_item(itm[S_TAIL+2])
    );
    aarm_cell #(.OP(aarm_pkg::OP_PAIR), .ARG(0), .FRAC(FRAC_BITS)) u_pair (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(vld[S_TAIL+2]), .in_item(itm[S_TAIL+2]),
        .out_valid(vld[S_TAIL+3]), .out_item(itm[S_TAIL+3])
    );
    aarm_cell #(.OP(aarm_pkg::OP_MOMC), .ARG(0), .FRAC(FRAC_BITS)) u_momc (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(vld[S_TAIL+3]), .in_item(itm[S_TAIL+3]),
        .out_valid(vld[S_TAIL+4]), .out_item(itm[S_TAIL+4])
    );
    aarm_cell #(.OP(aarm_pkg::OP_OUT), .ARG(0), .FRAC(FRAC_BITS)) u_out (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(vld[S_TAIL+4]), .in_item(itm[S_TAIL+4]),
        .out_valid(vld[N_CELL]), .out_item(itm[N_CELL])
    );

    assign res_in.zero = itm[N_CELL].zero;
    assign res_in.m    = itm[N_CELL].m;

    aarm_skid u_skid (
        .clk(clk),
        .rst_n(rst_n),
        .push(vld[N_CELL]),
        .push_data(res_in),
        .room(en),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data(res_out)
    );

    always_comb
    begin
        m_axis_tdata = '0;
        for (int k = 0; k < aarm_pkg::N_COEF; k++)
        begin
            m_axis_tdata[k*OUT_W +: OUT_W] = res_out.m[k][OUT_W-1:0];
        end
    end

    assign m_axis_tuser = res_out.zero;

endmodule

@@ design/aarm_checker.sv @@
// aarm_checker: port-level checks on the rotation-matrix block, bound to
// axis_angle_rotation_matrix. No package dependency.
module aarm_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    input logic                                 m_axis_tuser
);

    localparam int OUT_W = FRAC_BITS + 2;

    logic range_ok;
    logic ident_ok;

    always_comb
    begin
        logic signed [OUT_W-1:0] fld;
        logic signed [OUT_W-1:0] lim;
        lim      = OUT_W'(1) << FRAC_BITS;
        range_ok = 1'b1;
        ident_ok = 1'b1;
        for (int k = 0; k < 9; k++)
        begin
            fld = m_axis_tdata[k*OUT_W +: OUT_W];
            if (fld > lim || fld < -lim)
            begin
                range_ok = 1'b0;
            end
            if ((k == 0 || k == 4 || k == 8) ? (fld != lim) : (fld != '0))
            begin
                ident_ok = 1'b0;
            end
        end
    end

    // coefficients never leave the saturation range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> range_ok)
        else $error("coefficient outside +-1");

    // zero axis flag always comes with the identity
    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> ident_ok)
        else $error("zero_axis without identity matrix");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // an empty pipe after reset accepts input on the next cycle
    a_ready: assert property (@(posedge clk)
        !rst_n |=> s_axis_tready)
        else $error("not ready after reset");

endmodule

bind axis_angle_rotation_matrix aarm_checker #(.FRAC_BITS(FRAC_BITS)) u_aarm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
